// ===== rtl/mstb_pkg.sv =====
// Shared types and codes for the timer slot bank.
// Holds the command and result word layouts and the cell-to-cell link.
// No dependencies.
package mstb_pkg;

	// Command opcodes.
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_ALLOC = 2'd1;
	localparam logic [1:0] OP_ARM   = 2'd2;

	// Result event codes.
	localparam logic [1:0] EV_ALLOCATED = 2'd0;
	localparam logic [1:0] EV_NO_FREE   = 2'd1;
	localparam logic [1:0] EV_EXPIRED   = 2'd2;

	// One command word.
	typedef struct packed {
		logic [1:0]  opcode;
		logic [2:0]  slot;
		logic [15:0] period;
		logic        periodic;
		logic        notify;
	} cmd_word_t;

	// One result word.
	typedef struct packed {
		logic [1:0] event_res;
		logic [2:0] slot_id;
		logic       last;
	} res_word_t;

	// What a cell hands on: the sweep token and its own hit flag.
	typedef struct packed {
		logic tok;
		logic hit;
	} cell_link_t;

endpackage

// ===== rtl/multi_slot_timer_bank.sv =====
// Top level of the timer slot bank: a chain of slot cells plus the sweep control.
// Depends on mstb_pkg and mstb_cell.
//
// Usage: a command word on cmd is taken at a clock edge where start is high and
// busy is low. Arm takes effect at that edge and gives no result; busy stays low.
// Allocate and tick launch a token that walks the chain of slots, one slot per
// cycle, so busy is high while the token travels.
// Allocate: the first free slot claims the token; its result appears in the cycle
// right after that slot's visit, and if no slot is free the result follows the
// last slot's visit. Tick: expiry results come out in slot order, one pending in
// a holding register so the final one can carry last.
// Each result is on result for one cycle with result_stb high; the receiver
// cannot stall it. Reset clears every slot to free and stopped and drops busy.
// Slot numbers wider than slot_id are reported modulo eight.
module multi_slot_timer_bank #(
	parameter int NUM_SLOTS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  mstb_pkg::cmd_word_t cmd,
	output logic                result_stb,
	output mstb_pkg::res_word_t result
);
	import mstb_pkg::*;

	cell_link_t       links [NUM_SLOTS];
	logic [NUM_SLOTS-1:0] tok_chain;

	logic       busy_q;
	logic       launch_q;
	logic       tick_q;
	logic       pend_v_q;
	logic [2:0] pend_id_q;
	logic       stb_q;
	res_word_t  res_q;

	logic       accept;
	logic       arm_en;
	logic       hit_any;
	logic [2:0] hit_idx;
	logic       sweep_end;

	assign accept = start && !busy_q;
	assign arm_en = accept && (cmd.opcode == OP_ARM);

	// The chain of slot cells; each takes its token from the one before, the first from launch_q.
	for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign tok_chain[i] = launch_q;
		end else begin : g_link
			assign tok_chain[i] = links[i-1].tok;
		end
		mstb_cell #(.IDX(i)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.tok_in   (tok_chain[i]),
			.tick_mode(tick_q),
			.arm_en   (arm_en),
			.cmd      (cmd),
			.link     (links[i])
		);
	end

	// Only the cell holding the token can hit, so an OR gives its number.
	always_comb begin
		hit_any = 1'b0;
		hit_idx = '0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			if (links[i].hit) begin
				hit_any = 1'b1;
				hit_idx = hit_idx | 3'(i);
			end
		end
		sweep_end = links[NUM_SLOTS-1].tok;
	end

	// Sweep control and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			launch_q  <= 1'b0;
			tick_q    <= 1'b0;
			pend_v_q  <= 1'b0;
			pend_id_q <= '0;
			stb_q     <= 1'b0;
			res_q     <= '0;
		end else begin
			launch_q <= 1'b0;
			stb_q    <= 1'b0;
			if (accept && (cmd.opcode == OP_TICK || cmd.opcode == OP_ALLOC)) begin
				busy_q   <= 1'b1;
				launch_q <= 1'b1;
				tick_q   <= (cmd.opcode == OP_TICK);
				pend_v_q <= 1'b0;
			end else if (busy_q) begin
				if (hit_any) begin
					if (tick_q) begin
						// Release the held expiry; the new one waits.
						if (pend_v_q) begin
							stb_q <= 1'b1;
							res_q <= '{event_res: EV_EXPIRED, slot_id: pend_id_q, last: 1'b0};
						end
						pend_v_q  <= 1'b1;
						pend_id_q <= hit_idx;
					end else begin
						stb_q  <= 1'b1;
						res_q  <= '{event_res: EV_ALLOCATED, slot_id: hit_idx, last: 1'b1};
						busy_q <= 1'b0;
					end
				end else if (sweep_end) begin
					busy_q <= 1'b0;
					if (tick_q) begin
						if (pend_v_q) begin
							stb_q <= 1'b1;
							res_q <= '{event_res: EV_EXPIRED, slot_id: pend_id_q, last: 1'b1};
						end
					end else begin
						stb_q <= 1'b1;
						res_q <= '{event_res: EV_NO_FREE, slot_id: 3'd0, last: 1'b1};
					end
				end
			end
		end
	end

	assign busy       = busy_q;
	assign result_stb = stb_q;
	assign result     = res_q;

endmodule

// ===== rtl/mstb_cell.sv =====
// One timer slot of the bank, a link in the sweep chain.
// Depends on mstb_pkg for the command word and the link struct.
module mstb_cell #(
	parameter int IDX = 0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               tok_in,
	input  logic               tick_mode,
	input  logic               arm_en,
	input  mstb_pkg::cmd_word_t cmd,
	output mstb_pkg::cell_link_t link
);
	import mstb_pkg::*;

	logic        in_use_q;
	logic        running_q;
	logic        reload_q;
	logic        notify_q;
	logic [15:0] remain_q;
	logic [15:0] period_q;
	logic        tok_q;

	logic        my_arm;
	logic        do_tick;
	logic        do_claim;
	logic [15:0] dec;
	logic        expire;

	// Decode what this slot does in the current cycle.
	always_comb begin
		my_arm   = arm_en && (32'(cmd.slot) == IDX);
		do_tick  = tok_in && tick_mode && in_use_q && running_q;
		do_claim = tok_in && !tick_mode && !in_use_q;
		dec      = (remain_q != 16'd0) ? (remain_q - 16'd1) : 16'd0;
		expire   = do_tick && (dec == 16'd0);
	end

	// Slot state and the token handed to the next cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q  <= 1'b0;
			running_q <= 1'b0;
			reload_q  <= 1'b0;
			notify_q  <= 1'b0;
			remain_q  <= '0;
			period_q  <= '0;
			tok_q     <= 1'b0;
		end else begin
			tok_q <= tok_in && !do_claim;
			if (do_claim) begin
				in_use_q  <= 1'b1;
				running_q <= 1'b0;
				reload_q  <= 1'b0;
				notify_q  <= 1'b0;
				remain_q  <= '0;
				period_q  <= '0;
			end else if (my_arm && in_use_q) begin
				period_q  <= cmd.period;
				reload_q  <= cmd.periodic;
				notify_q  <= cmd.notify;
				remain_q  <= cmd.period;
				running_q <= 1'b1;
			end else if (do_tick) begin
				if (expire && reload_q) begin
					remain_q <= period_q;
				end else begin
					remain_q <= dec;
				end
				if (expire && !reload_q) begin
					running_q <= 1'b0;
				end
			end
		end
	end

	// A claim or a notifying expiry counts as a hit.
	assign link.tok = tok_q;
	assign link.hit = do_claim || (expire && notify_q);

endmodule

// ===== test/mstb_result_checker.sv =====
// Result checker for the timer slot bank: tracks the slot table from accepted command
// words and compares every result word with the oldest one it predicted.
// Depends on mstb_pkg.
module mstb_result_checker #(
	parameter int NUM_SLOTS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                busy,
	input  mstb_pkg::cmd_word_t cmd,
	input  logic                result_stb,
	input  mstb_pkg::res_word_t result,
	output int                  mismatches,
	output int                  outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	import mstb_pkg::*;

	// Shadow copy of the slot table.
	logic        slot_used   [NUM_SLOTS];
	logic        slot_active [NUM_SLOTS];
	logic        slot_reload [NUM_SLOTS];
	logic        slot_notify [NUM_SLOTS];
	logic [15:0] slot_count  [NUM_SLOTS];
	logic [15:0] slot_period [NUM_SLOTS];

	// Result words predicted but not yet seen, oldest first.
	res_word_t due_results[$];

	// Applies one command word to the shadow table and queues the result words it causes.
	task automatic apply_command(input cmd_word_t w);
		res_word_t r;
		res_word_t held;
		logic      have_held;
		logic      found;
		found = 1'b0;
		have_held = 1'b0;
		held = '0;
		r = '0;
		case (w.opcode)
			OP_ALLOC: begin
				for (int s = 0; s < NUM_SLOTS; s++) begin
					if (!found && !slot_used[s]) begin
						found = 1'b1;
						slot_used[s] = 1'b1;
						slot_active[s] = 1'b0;
						slot_reload[s] = 1'b0;
						slot_notify[s] = 1'b0;
						slot_count[s] = '0;
						slot_period[s] = '0;
						r.event_res = EV_ALLOCATED;
						r.slot_id = 3'(s);
					end
				end
				if (!found) begin
					r.event_res = EV_NO_FREE;
					r.slot_id = '0;
				end
				r.last = 1'b1;
				due_results.push_back(r);
			end
			OP_ARM: begin
				if (int'(w.slot) < NUM_SLOTS && slot_used[w.slot]) begin
					slot_period[w.slot] = w.period;
					slot_reload[w.slot] = w.periodic;
					slot_notify[w.slot] = w.notify;
					slot_count[w.slot] = w.period;
					slot_active[w.slot] = 1'b1;
				end
			end
			OP_TICK: begin
				// One expiry word is held back so that the final one can carry last.
				for (int s = 0; s < NUM_SLOTS; s++) begin
					if (slot_used[s] && slot_active[s]) begin
						if (slot_count[s] != 16'd0)
							slot_count[s] = slot_count[s] - 16'd1;
						if (slot_count[s] == 16'd0) begin
							if (slot_notify[s]) begin
								if (have_held)
									due_results.push_back(held);
								held.event_res = EV_EXPIRED;
								held.slot_id = 3'(s);
								held.last = 1'b0;
								have_held = 1'b1;
							end
							if (slot_reload[s])
								slot_count[s] = slot_period[s];
							else
								slot_active[s] = 1'b0;
						end
					end
				end
				if (have_held) begin
					held.last = 1'b1;
					due_results.push_back(held);
				end
			end
			default: begin
				// The spare opcode leaves the table alone.
			end
		endcase
	endtask

	// Clear the table in reset; otherwise compare each result word, then predict
	// from each accepted command word.
	always @(posedge clk) begin
		res_word_t want;
		if (!arst_n) begin
			mismatches = 0;
			due_results.delete();
			for (int s = 0; s < NUM_SLOTS; s++) begin
				slot_used[s] = 1'b0;
				slot_active[s] = 1'b0;
				slot_reload[s] = 1'b0;
				slot_notify[s] = 1'b0;
				slot_count[s] = '0;
				slot_period[s] = '0;
			end
		end else begin
			if (result_stb) begin
				if (due_results.size() == 0) begin
					$error("unexpected result word: event_res %0d slot_id %0d last %0d",
						result.event_res, result.slot_id, result.last);
					mismatches = mismatches + 1;
				end else begin
					want = due_results.pop_front();
					if (result.event_res !== want.event_res) begin
						$error("event_res: expected %0d, got %0d",
							want.event_res, result.event_res);
						mismatches = mismatches + 1;
					end
					if (result.slot_id !== want.slot_id) begin
						$error("slot_id: expected %0d, got %0d", want.slot_id, result.slot_id);
						mismatches = mismatches + 1;
					end
					if (result.last !== want.last) begin
						$error("last: expected %0d, got %0d", want.last, result.last);
						mismatches = mismatches + 1;
					end
				end
			end
			if (start && !busy)
				apply_command(cmd);
		end
		outstanding <= due_results.size();
	end

endmodule

// ===== test/multi_slot_timer_bank_tb.sv =====
// Testbench top for the timer slot bank: clock, reset, directed and random command words.
// Depends on mstb_pkg, multi_slot_timer_bank and mstb_result_checker.
module multi_slot_timer_bank_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mstb_pkg::*;

	localparam int NUM_SLOTS = 8;
	localparam logic [1:0] OP_SPARE = 2'd3;
	localparam int RANDOM_WORDS = 388;
	localparam int DRAIN_CYCLES = NUM_SLOTS + 8;
	localparam int STALL_LIMIT = 400;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      start;
	logic      busy;
	cmd_word_t cmd;
	logic      result_stb;
	res_word_t result;
	int        mismatches;
	int        outstanding;
	int        quiet_cycles = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	multi_slot_timer_bank #(
		.NUM_SLOTS(NUM_SLOTS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.result_stb(result_stb),
		.result(result)
	);

	mstb_result_checker #(
		.NUM_SLOTS(NUM_SLOTS)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.result_stb(result_stb),
		.result(result),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	// Watchdog: ends the run when no word moves in either direction for too long.
	always @(posedge clk) begin
		if ((start && !busy) || result_stb) begin
			quiet_cycles <= 0;
		end else begin
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic cmd_word_t make_word(input logic [1:0] op, input logic [2:0] slot,
			input logic [15:0] period, input logic periodic, input logic notify);
		cmd_word_t w;
		w.opcode = op;
		w.slot = slot;
		w.period = period;
		w.periodic = periodic;
		w.notify = notify;
		return w;
	endfunction

	// Mostly short periods so that expiries are frequent; now and then any value.
	function automatic logic [15:0] pick_period();
		if ($urandom_range(0, 9) < 7)
			return 16'($urandom_range(0, 6));
		return 16'($urandom);
	endfunction

	function automatic cmd_word_t random_word();
		cmd_word_t w;
		int        pick;
		w = make_word(2'($urandom), 3'($urandom), pick_period(), 1'($urandom), 1'($urandom));
		pick = $urandom_range(0, 99);
		if (pick < 45)
			w.opcode = OP_TICK;
		else if (pick < 90)
			w.opcode = OP_ARM;
		else if (pick < 95)
			w.opcode = OP_ALLOC;
		else
			w.opcode = OP_SPARE;
		return w;
	endfunction

	// Holds start high with the word until the block takes it.
	task automatic send_word(input cmd_word_t w);
		start <= 1'b1;
		cmd <= w;
		do @(posedge clk); while (busy);
	endtask

	// Stops sending until every predicted result word has come back.
	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0 || busy)
			@(posedge clk);
	endtask

	initial begin
		int sent;
		int burst;
		int gap;
		logic paused;
		sent = 0;
		paused = 1'b0;
		start <= 1'b0;
		cmd <= '0;
		arst_n <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: empty bank, ignored words, zero period, restart, silent expiry,
		// a full bank and the largest period.
		send_word(make_word(OP_TICK, 3'd0, 16'd0, 1'b0, 1'b0));
		send_word(make_word(OP_ARM, 3'd3, 16'd5, 1'b1, 1'b1));
		send_word(make_word(OP_SPARE, 3'd7, 16'hFFFF, 1'b1, 1'b1));
		send_word(make_word(OP_ALLOC, 3'd0, 16'd0, 1'b0, 1'b0));
		send_word(make_word(OP_ARM, 3'd0, 16'd0, 1'b1, 1'b1));
		send_word(make_word(OP_TICK, 3'd0, 16'd0, 1'b0, 1'b0));
		send_word(make_word(OP_TICK, 3'd0, 16'd0, 1'b0, 1'b0));
		send_word(make_word(OP_ALLOC, 3'd0, 16'd0, 1'b0, 1'b0));
		send_word(make_word(OP_ARM, 3'd1, 16'd1, 1'b0, 1'b1));
		send_word(make_word(OP_ARM, 3'd0, 16'd2, 1'b1, 1'b1));
		send_word(make_word(OP_TICK, 3'd0, 16'd0, 1'b0, 1'b0));
		send_word(make_word(OP_TICK, 3'd0, 16'd0, 1'b0, 1'b0));
		send_word(make_word(OP_ALLOC, 3'd0, 16'd0, 1'b0, 1'b0));
		send_word(make_word(OP_ARM, 3'd2, 16'd0, 1'b0, 1'b0));
		send_word(make_word(OP_TICK, 3'd0, 16'd0, 1'b0, 1'b0));
		for (int i = 0; i < 5; i++)
			send_word(make_word(OP_ALLOC, 3'd0, 16'd0, 1'b0, 1'b0));
		send_word(make_word(OP_ALLOC, 3'd0, 16'd0, 1'b0, 1'b0));
		send_word(make_word(OP_ARM, 3'd7, 16'hFFFF, 1'b1, 1'b1));
		for (int s = 3; s < 7; s++)
			send_word(make_word(OP_ARM, 3'(s), 16'd0, 1'b1, 1'b1));
		send_word(make_word(OP_TICK, 3'd0, 16'd0, 1'b0, 1'b0));
		wait_drained();

		// Random part: bursts of words with random gaps, one full drain halfway.
		while (sent < RANDOM_WORDS) begin
			burst = $urandom_range(1, 12);
			for (int i = 0; i < burst && sent < RANDOM_WORDS; i++) begin
				send_word(random_word());
				sent++;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (!paused && sent >= RANDOM_WORDS / 2) begin
				paused = 1'b1;
				wait_drained();
			end else if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end

		// Let the last words finish, then give the verdict.
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (outstanding != 0)
			$error("%0d predicted result words never arrived", outstanding);
		if (mismatches == 0 && outstanding == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
